// ===== src/eno_rf2_pkg.sv =====
package eno_rf2_pkg;

	// default coarse sample width
	localparam int DATA_W_DEF = 24;
	// extra fraction bits on fine values (units of 1/8)
	localparam int FRAC_W = 3;
	// headroom for stencil sums and differences, above DATA_W
	localparam int EXT_W = 6;

endpackage

// ===== src/eno_rf2_in_if.sv =====
interface eno_rf2_in_if #(
	parameter int DATA_W = 24
);
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sample;
	logic                     line_start;

	modport source (output valid, output sample, output line_start, input ready);
	modport sink (input valid, input sample, input line_start, output ready);
endinterface

// ===== src/eno_rf2_out_if.sv =====
interface eno_rf2_out_if #(
	parameter int OUT_W = 27
);
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] fine_value;
	logic                    last;
	logic                    limited;

	modport source (output valid, output fine_value, output last, output limited, input ready);
	modport sink (input valid, input fine_value, input last, input limited, output ready);
endinterface

// ===== src/eno_rf2_stencil.sv =====
module eno_rf2_stencil
	import eno_rf2_pkg::*;
#(
	parameter int DATA_W = DATA_W_DEF
) (
	input  logic signed [DATA_W-1:0]        f [5],
	output logic signed [DATA_W+FRAC_W-1:0] left,
	output logic signed [DATA_W+FRAC_W-1:0] right,
	output logic                            limited
);

	localparam int EW    = DATA_W + EXT_W;
	localparam int OUT_W = DATA_W + FRAC_W;

	localparam logic [1:0] PICK_L = 2'd0;
	localparam logic [1:0] PICK_C = 2'd1;
	localparam logic [1:0] PICK_R = 2'd2;

	function automatic logic is_pos(input logic signed [EW-1:0] v);
		return !v[EW-1] && (|v);
	endfunction

	function automatic logic is_neg(input logic signed [EW-1:0] v);
		return v[EW-1];
	endfunction

	// product strictly below zero
	function automatic logic opp(input logic signed [EW-1:0] a, input logic signed [EW-1:0] b);
		return (is_pos(a) && is_neg(b)) || (is_neg(a) && is_pos(b));
	endfunction

	// product at or below zero
	function automatic logic not_same(input logic signed [EW-1:0] a,
		input logic signed [EW-1:0] b);
		return !((is_pos(a) && is_pos(b)) || (is_neg(a) && is_neg(b)));
	endfunction

	function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] v);
		return v[EW-1] ? EW'(-v) : EW'(v);
	endfunction

	logic signed [EW-1:0] x [5];
	logic signed [EW-1:0] d0, d1, d2;
	logic        [EW-1:0] m0, m1, m2;
	logic signed [EW-1:0] st_l, st_c, st_r, c8, lft, rgt;
	logic        [1:0]    pick;
	logic                 sign_lim, int_lim;

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			x[i] = {{(EW-DATA_W){f[i][DATA_W-1]}}, f[i]};
		end
	end

	assign d0 = x[0] - (x[1] <<< 1) + x[2];
	assign d1 = x[1] - (x[2] <<< 1) + x[3];
	assign d2 = x[2] - (x[3] <<< 1) + x[4];
	assign m0 = mag(d0);
	assign m1 = mag(d1);
	assign m2 = mag(d2);

	assign c8   = x[2] <<< 3;
	assign st_l = (x[1] <<< 2) + (x[2] <<< 2) + x[2] - x[0];
	assign st_c = x[1] + c8 - x[3];
	assign st_r = c8 + (x[2] <<< 1) + x[2] - (x[3] <<< 2) + x[4];

	assign sign_lim = not_same(d0, d2) || not_same(d0, d1) || not_same(d1, d2);

	// ties keep centre, then left
	always_comb begin
		pick = PICK_C;
		if (m0 < m1) begin
			pick = PICK_L;
		end
		if ((pick == PICK_L) ? (m2 < m0) : (m2 < m1)) begin
			pick = PICK_R;
		end
	end

	always_comb begin
		if (sign_lim) begin
			lft = c8;
		end else begin
			case (pick)
				PICK_L:  lft = st_l;
				PICK_R:  lft = st_r;
				default: lft = st_c;
			endcase
		end
	end

	assign rgt     = (c8 <<< 1) - lft;
	assign int_lim = opp(lft - (x[1] <<< 3), c8 - lft) || opp((x[3] <<< 3) - rgt, rgt - c8);

	assign limited = sign_lim || int_lim;
	assign left    = int_lim ? c8[OUT_W-1:0] : lft[OUT_W-1:0];
	assign right   = int_lim ? c8[OUT_W-1:0] : rgt[OUT_W-1:0];

endmodule

// ===== src/eno_conservative_refine_by_two_unit.sv =====
// Channel  Dir  Beat payload                                    Handshake
// coarse   in   sample (DATA_W, signed), line_start             valid/ready
// fine     out  fine_value (DATA_W+3, signed), last, limited    valid/ready
//
// Two fine beats (left, then right) per coarse sample once the window holds
// four earlier samples of the line; earlier samples give no beats.
// A taken sample passes stage 1 and then the pair register before its left beat is offered.
// The fine channel's two beats set the rate; stage 1 can take the next sample meanwhile.
// arst_n clears window, fill count and all valid flags.
// A stalled fine channel holds the pair register, then the stage register and coarse.ready.
module eno_conservative_refine_by_two_unit
	import eno_rf2_pkg::*;
#(
	parameter int DATA_W = DATA_W_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	eno_rf2_in_if.sink           coarse,
	eno_rf2_out_if.source        fine
);

	localparam int OUT_W = DATA_W + FRAC_W;

	// window of four earlier samples, oldest first
	logic signed [DATA_W-1:0] window_q [4];
	logic        [2:0]        fill_q;
	logic        [2:0]        fill_eff;
	logic                     in_fire;

	// stage 1: full five-sample window
	logic signed [DATA_W-1:0] f_s1 [5];
	logic                     valid_s1;
	logic                     adv_s1;

	// pair register: left and right fine values
	logic signed [OUT_W-1:0]  left_q, right_q;
	logic                     lim_q;
	logic                     pair_v_q;
	logic                     phase_q;   // 0: left beat due, 1: right beat due
	logic                     out_fire;
	logic                     pair_load;

	logic signed [OUT_W-1:0]  left_c, right_c;
	logic                     lim_c;

	assign in_fire  = coarse.valid && coarse.ready;
	assign fill_eff = coarse.line_start ? 3'd0 : fill_q;

	assign out_fire  = pair_v_q && fine.ready;
	// pair register free, or its right beat leaves this cycle
	assign pair_load = !pair_v_q || (out_fire && phase_q);
	assign adv_s1    = !valid_s1 || pair_load;
	assign coarse.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				window_q[i] <= '0;
			end
			fill_q <= '0;
		end else if (in_fire) begin
			for (int i = 0; i < 3; i++) begin
				window_q[i] <= window_q[i+1];
			end
			window_q[3] <= coarse.sample;
			fill_q      <= fill_eff[2] ? fill_eff : fill_eff + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			// only a sample arriving on a full window yields a pair
			valid_s1 <= in_fire && fill_eff[2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_fire) begin
			for (int i = 0; i < 4; i++) begin
				f_s1[i] <= window_q[i];
			end
			f_s1[4] <= coarse.sample;
		end
	end

	eno_rf2_stencil #(
		.DATA_W (DATA_W)
	) u_stencil (
		.f       (f_s1),
		.left    (left_c),
		.right   (right_c),
		.limited (lim_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_v_q <= 1'b0;
			phase_q  <= 1'b0;
		end else if (pair_load) begin
			pair_v_q <= valid_s1;
			phase_q  <= 1'b0;
		end else if (out_fire) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pair_load && valid_s1) begin
			left_q  <= left_c;
			right_q <= right_c;
			lim_q   <= lim_c;
		end
	end

	assign fine.valid      = pair_v_q;
	assign fine.fine_value = phase_q ? right_q : left_q;
	assign fine.last       = phase_q;
	assign fine.limited    = lim_q;

endmodule
